/* sv/nsag_pkg.sv */
// Shared types and constants for the nearest stretch address generator.
`default_nettype none

package nsag_pkg;

  // Destination frame buffer row stride, in bytes.
  localparam logic [19:0] DST_ROW_BYTES = 20'd640;

  // 1.0 in 9.16 fixed point, at accumulator width.
  localparam logic [24:0] ONE_FIX = 25'h001_0000;

  // Configuration register map, word index (byte address / 4).
  typedef enum logic [2:0] {
    REG_SRC_X       = 3'd0,
    REG_SRC_Y       = 3'd1,
    REG_SRC_PITCH   = 3'd2,
    REG_DST_COLS    = 3'd3,
    REG_DST_HEIGHT  = 3'd4,
    REG_H_INCREMENT = 3'd5,
    REG_V_INCREMENT = 3'd6
  } reg_idx_t;

endpackage

`default_nettype wire

/* sv/nearest_stretch_address_generator_core.sv */
// Top level of the nearest stretch address generator: config registers and datapath.
`default_nettype none

// Address generator for a nearest-neighbor stretch blit of 16-bit pixels.
// Every accepted input beat produces exactly one result beat carrying the
// source byte offset to read, the destination byte offset to write, and
// row-end / frame-end marks. A beat with in_start_req high restarts the frame
// at its first pixel; after the last pixel of a frame the next beat starts a
// new frame on its own. Two 9.16 accumulators walk the source: h_increment
// and v_increment are the precomputed source/destination ratios, so no
// division happens here. Throughput is one beat per clock while out_stall is
// low; beats pass an input register, then the result register. The critical
// path is the per-pixel state update: a 9x13 multiply of the row advance by
// the pitch, then the offset adds, all combinational. Registers sit on the
// APB port at byte addresses 4*i (src_x, src_y, src_pitch, destination row
// width, dst_height, h_increment, v_increment); writes take effect immediately
// but must only be issued while the block is idle. A zero width or height acts
// as one. Source offsets wrap at 24 bits, destination offsets at 20 bits.
module nearest_stretch_address_generator_core
  import nsag_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_start_req,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_src_offset,
  output logic [19:0]      out_dst_offset,
  output logic             out_row_end,
  output logic             out_frame_end,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [11:0] src_x_r;
  logic [11:0] src_y_r;
  logic [12:0] src_pitch_r;
  logic [8:0]  dst_cols_r;
  logic [9:0]  dst_height_r;
  logic [23:0] h_inc_r;
  logic [23:0] v_inc_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_x_r      <= 12'd0;
      src_y_r      <= 12'd0;
      src_pitch_r  <= 13'd640;
      dst_cols_r   <= 9'd320;
      dst_height_r <= 10'd240;
      h_inc_r      <= 24'h01_0000;
      v_inc_r      <= 24'h01_0000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_X:       src_x_r      <= pwdata[11:0];
        REG_SRC_Y:       src_y_r      <= pwdata[11:0];
        REG_SRC_PITCH:   src_pitch_r  <= pwdata[12:0];
        REG_DST_COLS:    dst_cols_r   <= pwdata[8:0];
        REG_DST_HEIGHT:  dst_height_r <= pwdata[9:0];
        REG_H_INCREMENT: h_inc_r      <= pwdata[23:0];
        REG_V_INCREMENT: v_inc_r      <= pwdata[23:0];
        default: ;  // unmapped word: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SRC_X:       prdata = {20'd0, src_x_r};
      REG_SRC_Y:       prdata = {20'd0, src_y_r};
      REG_SRC_PITCH:   prdata = {19'd0, src_pitch_r};
      REG_DST_COLS:    prdata = {23'd0, dst_cols_r};
      REG_DST_HEIGHT:  prdata = {22'd0, dst_height_r};
      REG_H_INCREMENT: prdata = {8'd0, h_inc_r};
      REG_V_INCREMENT: prdata = {8'd0, v_inc_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Frame base product src_y * pitch, kept registered off the critical path.
  // Config must only change while idle (not enforced here), so it is settled
  // before the next beat reaches the datapath.
  logic [24:0] frame_prod;
  logic [23:0] frame_base_r;

  assign frame_prod = src_y_r * src_pitch_r;

  always_ff @(posedge clk) begin
    frame_base_r <= frame_prod[23:0];
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeding the result register
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_start_r;
  logic advance;
  logic step;

  // Result register can take a new beat when empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign step     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_start_r <= in_start_req;
    end
  end

  // ---------------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------------
  logic [24:0] col_acc_r,   col_acc_nxt;
  logic [24:0] row_acc_r,   row_acc_nxt;
  logic [23:0] row_base_r,  row_base_nxt;   // byte offset of row after selected row
  logic [23:0] col_idx_r,   col_idx_nxt;    // index of pixel after selected pixel
  logic [8:0]  col_cnt_r,   col_cnt_nxt;
  logic [9:0]  row_cnt_r,   row_cnt_nxt;
  logic [19:0] dst_base_r,  dst_base_nxt;   // row_cnt * DST_ROW_BYTES

  // Step values after an optional restart
  logic [24:0] ca0, ra0;
  logic [23:0] rb0, ci0;
  logic [8:0]  cc0;
  logic [9:0]  rc0;
  logic [19:0] db0;

  // Values after the start-of-row advance
  logic        row_start;
  logic [8:0]  row_k;
  logic [21:0] row_prod;
  logic [24:0] ca1, ra1;
  logic [23:0] rb1, ci1;

  // Column advance and outputs
  logic [8:0]  col_k;
  logic [23:0] ci2;
  logic [23:0] sel_row, sel_col;
  logic [23:0] src_off;
  logic [19:0] dst_off;
  logic [8:0]  width;
  logic [9:0]  height;
  logic        last_col, last_row;

  always_comb begin
    // Restart on request.
    if (s1_start_r) begin
      ca0 = ONE_FIX;
      ra0 = ONE_FIX;
      rb0 = frame_base_r;
      ci0 = 24'd0;
      cc0 = 9'd0;
      rc0 = 10'd0;
      db0 = 20'd0;
    end else begin
      ca0 = col_acc_r;
      ra0 = row_acc_r;
      rb0 = row_base_r;
      ci0 = col_idx_r;
      cc0 = col_cnt_r;
      rc0 = row_cnt_r;
      db0 = dst_base_r;
    end

    // First pixel of a row: advance the source row by the vertical integer part.
    row_start = (cc0 == 9'd0);
    row_k     = ra0[24:16];
    row_prod  = row_k * src_pitch_r;
    if (row_start) begin
      ra1 = {9'd0, ra0[15:0]};
      rb1 = rb0 + {2'd0, row_prod};
      ca1 = ONE_FIX;
      ci1 = 24'd0;
    end else begin
      ra1 = ra0;
      rb1 = rb0;
      ca1 = ca0;
      ci1 = ci0;
    end

    // Advance the source column by the horizontal integer part.
    col_k = ca1[24:16];
    ci2   = ci1 + {15'd0, col_k};

    sel_row = rb1 - {11'd0, src_pitch_r};
    sel_col = ci2 - 24'd1;
    src_off = sel_row + {11'd0, src_x_r, 1'b0} + {sel_col[22:0], 1'b0};
    dst_off = db0 + {10'd0, cc0, 1'b0};

    width    = (dst_cols_r == 9'd0) ? 9'd1 : dst_cols_r;
    height   = (dst_height_r == 10'd0) ? 10'd1 : dst_height_r;
    last_col = ({1'b0, cc0} + 10'd1) >= {1'b0, width};
    last_row = ({1'b0, rc0} + 11'd1) >= {1'b0, height};

    // Default: stay in the row.
    col_acc_nxt  = {9'd0, ca1[15:0]} + {1'b0, h_inc_r};
    row_acc_nxt  = ra1;
    row_base_nxt = rb1;
    col_idx_nxt  = ci2;
    col_cnt_nxt  = cc0 + 9'd1;
    row_cnt_nxt  = rc0;
    dst_base_nxt = db0;

    if (last_col && last_row) begin
      // Frame done: next beat starts a fresh frame on its own.
      col_acc_nxt  = ONE_FIX;
      row_acc_nxt  = ONE_FIX;
      row_base_nxt = frame_base_r;
      col_idx_nxt  = 24'd0;
      col_cnt_nxt  = 9'd0;
      row_cnt_nxt  = 10'd0;
      dst_base_nxt = 20'd0;
    end else if (last_col) begin
      col_cnt_nxt  = 9'd0;
      row_acc_nxt  = ra1 + {1'b0, v_inc_r};
      row_cnt_nxt  = rc0 + 10'd1;
      dst_base_nxt = db0 + DST_ROW_BYTES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_acc_r  <= ONE_FIX;
      row_acc_r  <= ONE_FIX;
      row_base_r <= 24'd0;
      col_idx_r  <= 24'd0;
      col_cnt_r  <= 9'd0;
      row_cnt_r  <= 10'd0;
      dst_base_r <= 20'd0;
    end else if (step) begin
      col_acc_r  <= col_acc_nxt;
      row_acc_r  <= row_acc_nxt;
      row_base_r <= row_base_nxt;
      col_idx_r  <= col_idx_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      dst_base_r <= dst_base_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic        out_valid_r;
  logic [23:0] src_off_r;
  logic [19:0] dst_off_r;
  logic        row_end_r;
  logic        frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      src_off_r   <= src_off;
      dst_off_r   <= dst_off;
      row_end_r   <= last_col;
      frame_end_r <= last_col && last_row;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_src_offset = src_off_r;
  assign out_dst_offset = dst_off_r;
  assign out_row_end    = row_end_r;
  assign out_frame_end  = frame_end_r;

endmodule

`default_nettype wire

/* sv/nsag_checker.sv */
// Port-level checker for the nearest stretch address generator, with its bind.
`default_nettype none

module nsag_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_src_offset,
  input wire logic [19:0] out_dst_offset,
  input wire logic        out_row_end,
  input wire logic        out_frame_end
);

  // Frame end always lands on a row end.
  a_frame_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  // Destination offsets address 16-bit pixels.
  a_dst_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_dst_offset[0])
    else $error("odd destination offset");

  // Input only backs up behind a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_src_offset)
      && $stable(out_dst_offset) && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled result beat changed");

endmodule

bind nearest_stretch_address_generator_core nsag_props u_nsag_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_src_offset (out_src_offset),
  .out_dst_offset (out_dst_offset),
  .out_row_end    (out_row_end),
  .out_frame_end  (out_frame_end)
);

`default_nettype wire

/* dv/nsag_checker.sv */
// Checker for the nearest stretch address generator: predicts and compares result beats.
`timescale 1ns / 100ps

module nsag_checker
  import nsag_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_start_req,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [23:0] out_src_offset,
  input  wire logic [19:0] out_dst_offset,
  input  wire logic        out_row_end,
  input  wire logic        out_frame_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               err_count,
  output int               outstanding
);

  typedef struct packed {
    logic [23:0] src;
    logic [19:0] dst;
    logic        row_end;
    logic        frame_end;
  } pixel_addr_t;

  pixel_addr_t pending_addrs[$];
  int          errs;

  // Register copies.
  logic [11:0] left_col, top_row;
  logic [12:0] pitch;
  logic [8:0]  width_reg;
  logic [9:0]  height_reg;
  logic [23:0] h_step, v_step;

  // Walk state.
  logic [24:0] h_acc, v_acc;
  logic [23:0] row_base, col_idx;
  logic [8:0]  dcol;
  logic [9:0]  drow;

  function automatic void restart_frame();
    bit [63:0] prod;
    prod     = 64'(top_row) * 64'(pitch);
    h_acc    = ONE_FIX;
    v_acc    = ONE_FIX;
    row_base = prod[23:0];
    col_idx  = '0;
    dcol     = '0;
    drow     = '0;
  endfunction

  function automatic pixel_addr_t next_pixel_addr(input logic start);
    bit [63:0]   k, sum, sel_row, sel_col, w, h;
    pixel_addr_t p;
    if (start) restart_frame();
    // First pixel of a row: advance the source row by the vertical integer part.
    if (dcol == 0) begin
      k        = 64'(v_acc[24:16]);
      v_acc    = {9'd0, v_acc[15:0]};
      sum      = 64'(row_base) + k * 64'(pitch);
      row_base = sum[23:0];
      h_acc    = ONE_FIX;
      col_idx  = '0;
    end
    k       = 64'(h_acc[24:16]);
    h_acc   = {9'd0, h_acc[15:0]};
    sum     = 64'(col_idx) + k;
    col_idx = sum[23:0];
    sel_row = 64'(row_base) - 64'(pitch);
    sel_col = 64'(col_idx) - 64'd1;
    sum     = sel_row + 2 * 64'(left_col) + 2 * sel_col;
    p.src   = sum[23:0];
    sum     = 64'(drow) * 64'(DST_ROW_BYTES) + 2 * 64'(dcol);
    p.dst   = sum[19:0];
    sum     = 64'(h_acc) + 64'(h_step);
    h_acc   = sum[24:0];
    w = (width_reg == 0) ? 64'd1 : 64'(width_reg);
    h = (height_reg == 0) ? 64'd1 : 64'(height_reg);
    p.row_end   = (64'(dcol) + 1 >= w);
    p.frame_end = p.row_end && (64'(drow) + 1 >= h);
    if (p.row_end) begin
      dcol  = '0;
      sum   = 64'(v_acc) + 64'(v_step);
      v_acc = sum[24:0];
      if (p.frame_end) restart_frame();
      else drow = drow + 10'd1;
    end else begin
      dcol = dcol + 9'd1;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_addr_t want, got;
    if (!rst_n) begin
      left_col   = '0;
      top_row    = '0;
      pitch      = 13'd640;
      width_reg  = 9'd320;
      height_reg = 10'd240;
      h_step     = 24'h01_0000;
      v_step     = 24'h01_0000;
      h_acc      = ONE_FIX;
      v_acc      = ONE_FIX;
      row_base   = '0;
      col_idx    = '0;
      dcol       = '0;
      drow       = '0;
      errs       = 0;
      pending_addrs.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_SRC_X:       left_col   = pwdata[11:0];
          REG_SRC_Y:       top_row    = pwdata[11:0];
          REG_SRC_PITCH:   pitch      = pwdata[12:0];
          REG_DST_COLS:    width_reg  = pwdata[8:0];
          REG_DST_HEIGHT:  height_reg = pwdata[9:0];
          REG_H_INCREMENT: h_step     = pwdata[23:0];
          REG_V_INCREMENT: v_step     = pwdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_addrs.push_back(next_pixel_addr(in_start_req));
      if (out_valid && !out_stall) begin
        got = '{out_src_offset, out_dst_offset, out_row_end, out_frame_end};
        if (pending_addrs.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result beat src %h dst %h row_end %b frame_end %b",
                     $realtime, got.src, got.dst, got.row_end, got.frame_end);
        end else begin
          want = pending_addrs.pop_front();
          if (got.src !== want.src || got.dst !== want.dst ||
              got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
            errs++;
            if (errs <= 10)
              $display("%0t: exp/got src %h/%h dst %h/%h row %b/%b frame %b/%b",
                       $realtime, want.src, got.src, want.dst, got.dst,
                       want.row_end, got.row_end, want.frame_end, got.frame_end);
          end
        end
      end
    end
    err_count   <= errs;
    outstanding <= pending_addrs.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the nearest stretch address generator: stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import nsag_pkg::*;

  // End the run when this many cycles pass with no beat and no register write.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 950;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_start_req = 1'b0;
  logic        in_stall;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_src_offset;
  logic [19:0] out_dst_offset;
  logic        out_row_end;
  logic        out_frame_end;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          err_count;
  int          outstanding;
  int          idle_cycles = 0;
  // When set, neither side inserts gaps: lets the pipeline run at full rate.
  bit          calm = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  nearest_stretch_address_generator_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  nsag_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .err_count      (err_count),
    .outstanding    (outstanding)
  );

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Pick a register value: mostly in the usual range, sometimes an extreme or
  // any value of the field. Junk above the field width checks the masking.
  function automatic logic [31:0] pick(input logic [31:0] typ_lo, typ_hi, field_max);
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0:       r = '0;
      1:       r = field_max;
      2, 3:    r = $urandom & field_max;
      default: r = $urandom_range(typ_lo, typ_hi);
    endcase
    if ($urandom_range(0, 3) == 0) r = r | ($urandom & ~field_max);
    return r;
  endfunction

  // Setup cycle, then access cycle held until pready; drop psel for one cycle
  // so back-to-back writes never lower and raise it in the same step.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Present one input beat after an optional gap and hold it until accepted.
  // Valid stays high on return so the next beat can follow without a bubble.
  task automatic send_beat(input logic start);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_run(input int n, input logic first_start);
    for (int i = 0; i < n; i++) send_beat(i == 0 ? first_start : 1'b0);
  endtask

  // Drop valid and wait until every predicted result has come out, plus a
  // short pause covering the two-stage pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Receiver side: random stalls with the same gap profile.
  initial begin
    int unsigned n;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog: count cycles where nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First frame after reset without a start: the walk begins at source row 0
    // whatever src_y holds. Six pixels fill the 3x2 frame; the seventh starts
    // a new frame on its own. Max pitch, max and zero increments.
    cfg_write(REG_SRC_X, 32'd4095);
    cfg_write(REG_SRC_Y, 32'd7);
    cfg_write(REG_SRC_PITCH, 32'd8191);
    cfg_write(REG_DST_COLS, 32'd3);
    cfg_write(REG_DST_HEIGHT, 32'd2);
    cfg_write(REG_H_INCREMENT, 32'hFF_FFFF);
    cfg_write(REG_V_INCREMENT, 32'd0);
    send_run(7, 1'b0);
    settle();

    // Zero width and height act as one, so every pixel ends its frame.
    cfg_write(REG_SRC_X, 32'd0);
    cfg_write(REG_SRC_Y, 32'd4095);
    cfg_write(REG_SRC_PITCH, 32'd0);
    cfg_write(REG_DST_COLS, 32'd0);
    cfg_write(REG_DST_HEIGHT, 32'd0);
    cfg_write(REG_H_INCREMENT, 32'd0);
    cfg_write(REG_V_INCREMENT, 32'hFF_FFFF);
    send_run(3, 1'b1);
    settle();

    // Shrink width below the current count mid-frame: the row ends on the
    // next pixel. Then shrink height to the row count: the frame ends at
    // the end of the following row.
    cfg_write(REG_SRC_PITCH, 32'd640);
    cfg_write(REG_SRC_Y, 32'd3);
    cfg_write(REG_DST_COLS, 32'd8);
    cfg_write(REG_DST_HEIGHT, 32'd3);
    cfg_write(REG_H_INCREMENT, 32'h0_8000);
    cfg_write(REG_V_INCREMENT, 32'h1_8000);
    send_run(5, 1'b1);
    settle();
    cfg_write(REG_DST_COLS, 32'd2);
    send_run(1, 1'b0);
    settle();
    cfg_write(REG_DST_HEIGHT, 32'd1);
    send_run(2, 1'b0);
    settle();

    // Random phases: new register settings while idle, then a run of beats.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) cfg_write(REG_SRC_X, pick(0, 4095, 32'hFFF));
      if ($urandom_range(0, 3) != 0) cfg_write(REG_SRC_Y, pick(0, 4095, 32'hFFF));
      if ($urandom_range(0, 3) != 0) cfg_write(REG_SRC_PITCH, pick(0, 8191, 32'h1FFF));
      if ($urandom_range(0, 3) != 0) cfg_write(REG_DST_COLS, pick(1, 12, 32'h1FF));
      if ($urandom_range(0, 3) != 0) cfg_write(REG_DST_HEIGHT, pick(1, 6, 32'h3FF));
      if ($urandom_range(0, 3) != 0)
        cfg_write(REG_H_INCREMENT, pick(32'h4000, 32'h4_0000, 32'hFF_FFFF));
      if ($urandom_range(0, 3) != 0)
        cfg_write(REG_V_INCREMENT, pick(32'h4000, 32'h4_0000, 32'hFF_FFFF));
      n = $urandom_range(15, 60);
      for (int i = 0; i < n; i++)
        send_beat((i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 19) == 0);
      sent += n;
      settle();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
